>>> src/apq_pkg.sv
`default_nettype none

package apq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned PRIO_W        = 3;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned OCC_W         = 7;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXTRACTED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

  // one stored entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // input beat taken, latch it
    logic append;       // write latched entry at the tail
    logic step;         // issue the next sweep read
    logic shifting;     // sweep is the compaction pass
    logic shift_start;  // scan over, start compaction after the winner
    logic remove;       // compaction over, drop one from the count
    logic publish;      // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic insert_ok;    // incoming beat is an insert with room
    logic extract_ok;   // incoming beat is an extract with entries held
    logic sweep_done;   // no read pending and none left to issue
    logic out_free;     // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

>>> src/apq_ctrl.sv
`default_nettype none

module apq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire apq_pkg::sts_t sts_i,
  output apq_pkg::cmd_t      cmd_o
);

  apq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      apq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.insert_ok) begin
            state_d = apq_pkg::S_WRITE;
          end else if (sts_i.extract_ok) begin
            state_d = apq_pkg::S_SCAN;
          end else begin
            state_d = apq_pkg::S_DONE;
          end
        end
      end
      apq_pkg::S_WRITE: state_d = apq_pkg::S_DONE;
      apq_pkg::S_SCAN: begin
        if (sts_i.sweep_done) state_d = apq_pkg::S_SHIFT;
      end
      apq_pkg::S_SHIFT: begin
        if (sts_i.sweep_done) state_d = apq_pkg::S_DONE;
      end
      apq_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = apq_pkg::S_IDLE;
      end
      default: state_d = apq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      apq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      apq_pkg::S_WRITE: cmd_o.append = 1'b1;
      apq_pkg::S_SCAN: begin
        cmd_o.step        = 1'b1;
        cmd_o.shift_start = sts_i.sweep_done;
      end
      apq_pkg::S_SHIFT: begin
        cmd_o.step     = 1'b1;
        cmd_o.shifting = 1'b1;
        cmd_o.remove   = sts_i.sweep_done;
      end
      apq_pkg::S_DONE: cmd_o.publish = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/apq_dp.sv
`default_nettype none

module apq_dp #(
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         mode_i,
  input  wire logic [apq_pkg::ID_W-1:0]     entry_id_i,
  input  wire logic [apq_pkg::PRIO_W-1:0]   entry_priority_i,
  input  wire apq_pkg::cmd_t                cmd_i,
  output apq_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [apq_pkg::STATUS_W-1:0]      status_o,
  output logic [apq_pkg::ID_W-1:0]          served_id_o,
  output logic [apq_pkg::PRIO_W-1:0]        served_priority_o,
  output logic [apq_pkg::OCC_W-1:0]         occupancy_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  apq_pkg::entry_t mem_q [DEPTH];
  apq_pkg::entry_t rdata_q;
  apq_pkg::entry_t item_q;
  apq_pkg::entry_t best_q;
  apq_pkg::entry_t wr_data;
  apq_pkg::status_e res_q, res_d;

  logic [CW-1:0] count_q;
  logic [CW-1:0] rd_ptr_q;
  logic [IW-1:0] ridx_q;
  logic [IW-1:0] best_idx_q;
  logic          rvalid_q;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          full;
  logic          empty;

  logic                          out_valid_q;
  logic [apq_pkg::STATUS_W-1:0]  out_status_q;
  apq_pkg::entry_t               out_entry_q;
  logic [apq_pkg::OCC_W-1:0]     out_occ_q;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    if (!mode_i) begin
      res_d = full ? apq_pkg::ST_FULL : apq_pkg::ST_INSERTED;
    end else begin
      res_d = empty ? apq_pkg::ST_EMPTY : apq_pkg::ST_EXTRACTED;
    end
  end

  assign rd_en   = cmd_i.step && (rd_ptr_q < count_q);
  assign wr_en   = cmd_i.append || (cmd_i.shifting && rvalid_q);
  assign wr_addr = cmd_i.append ? count_q[IW-1:0] : ridx_q - IW'(1);
  assign wr_data = cmd_i.append ? item_q : rdata_q;

  assign sts_o.insert_ok  = !mode_i && !full;
  assign sts_o.extract_ok = mode_i && !empty;
  assign sts_o.sweep_done = !rvalid_q && (rd_ptr_q >= count_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[rd_ptr_q[IW-1:0]];
  end

  // latched beat and scan winner
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q.id   <= entry_id_i;
      item_q.prio <= entry_priority_i;
      res_q       <= res_d;
    end
    if (rvalid_q && !cmd_i.shifting) begin
      if (ridx_q == '0 || rdata_q.prio > best_q.prio) begin
        best_q     <= rdata_q;
        best_idx_q <= ridx_q;
      end
    end
    ridx_q <= rd_ptr_q[IW-1:0];
  end

  // count and sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= rd_en;
      if (cmd_i.load) begin
        rd_ptr_q <= '0;
      end else if (cmd_i.shift_start) begin
        rd_ptr_q <= CW'(best_idx_q) + CW'(1);
      end else if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + CW'(1);
      end
      if (cmd_i.append) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.remove) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_status_q <= res_q;
      out_entry_q  <= (res_q == apq_pkg::ST_EXTRACTED) ? best_q : '0;
      out_occ_q    <= apq_pkg::OCC_W'(count_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign served_id_o       = out_entry_q.id;
  assign served_priority_o = out_entry_q.prio;
  assign occupancy_o       = out_occ_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count above depth");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !full)
    else $error("append with no room");

  a_shift_after_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shifting && rvalid_q) |-> (ridx_q > best_idx_q))
    else $error("compaction write at or below the winner");

  a_remove_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.remove |-> !empty)
    else $error("remove with nothing held");
`endif

endmodule

`default_nettype wire

>>> src/array_priority_queue_top.sv
`default_nettype none

// Bounded priority queue kept as an unsorted array in arrival order. Each
// input beat is an insert (mode 0) or an extract (mode 1) and yields exactly
// one result beat carrying a status and the count held afterwards. Inserts
// append at the tail, or come back as full when DEPTH entries are held.
// Extracts return the highest-priority entry, the earliest arrival winning a
// tie, then close the gap by moving later entries down one slot; with nothing
// held they report empty. One item is in flight at a time. An insert passes
// through a write state before its result is loaded, while a rejected insert
// or an empty extract goes straight to loading its result. An extract scans
// the N held entries for the winner at slot w, then compacts the entries from
// slot w + 1 onward, then loads the result. Both the scan and the compaction
// go through the single read port and single write port of the entry memory,
// one slot per cycle. No clearing pass is needed after reset. A result waits
// in an output register, and the next beat is taken the cycle after the
// current result has been loaded there; a result that cannot be loaded because
// the previous one is still stalled holds the block until it moves.
module array_priority_queue_top #(
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input beats
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        mode_i,
  input  wire logic [apq_pkg::ID_W-1:0]    entry_id_i,
  input  wire logic [apq_pkg::PRIO_W-1:0]  entry_priority_i,
  // result beats
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [apq_pkg::STATUS_W-1:0]     status_o,
  output logic [apq_pkg::ID_W-1:0]         served_id_o,
  output logic [apq_pkg::PRIO_W-1:0]       served_priority_o,
  output logic [apq_pkg::OCC_W-1:0]        occupancy_o
);

  apq_pkg::cmd_t cmd;
  apq_pkg::sts_t sts;

  // sequencer: accept, append or scan-then-compact, publish
  apq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry memory, count, scan winner and output register
  apq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mode_i            (mode_i),
    .entry_id_i        (entry_id_i),
    .entry_priority_i  (entry_priority_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .served_id_o       (served_id_o),
    .served_priority_o (served_priority_o),
    .occupancy_o       (occupancy_o)
  );

endmodule

`default_nettype wire
